FILE: hdl/chacha20_stream_xor_core_assert.svh
`ifndef CHACHA20_STREAM_XOR_CORE_ASSERT_SVH
`define CHACHA20_STREAM_XOR_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CXS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cxs_pkg.sv
package cxs_pkg;

  // Cipher configuration
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = $clog2(ROUNDS);

  // Request queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = CFG_IDX_W'(3);

  localparam logic [63:0] KEY_RST_0 = 64'h0706050403020100;
  localparam logic [63:0] KEY_RST_1 = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] KEY_RST_2 = 64'h1716151413121110;
  localparam logic [63:0] KEY_RST_3 = 64'h1f1e1d1c1b1a1918;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [3:0][63:0]  key_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  // One queued request, tagged by the front with its place in the block
  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
    logic [5:0] pos;
    logic       new_blk;
  } entry_t;

  typedef struct packed {
    logic  start;
    word_t counter;
  } gen_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_status_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_ROUND,
    G_ADD
  } gen_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GEN,
    B_RUN
  } back_state_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic qr_t quarter(input word_t a, input word_t b, input word_t c,
                                  input word_t d);
    qr_t q;
    q.a = a + b;   q.d = rotl(d ^ q.a, 16);
    q.c = c + q.d; q.b = rotl(b ^ q.c, 12);
    q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
    q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
    return q;
  endfunction

  // Cipher input block: sigma, key, counter, zero nonce
  function automatic block_t init_block(input key_t key, input word_t ctr);
    block_t r;
    r[0] = SIGMA_0;
    r[1] = SIGMA_1;
    r[2] = SIGMA_2;
    r[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      r[4 + 2 * i] = key[i][31:0];
      r[5 + 2 * i] = key[i][63:32];
    end
    r[12] = ctr;
    r[13] = '0;
    r[14] = '0;
    r[15] = '0;
    return r;
  endfunction

  // One column round (diag low) or diagonal round (diag high) on four lanes
  function automatic block_t round_step(input block_t w, input logic diag);
    block_t r;
    qr_t    q;
    int     bi;
    int     ci;
    int     di;
    r = w;
    for (int i = 0; i < 4; i++) begin
      bi = diag ? 4 + ((i + 1) % 4) : 4 + i;
      ci = diag ? 8 + ((i + 2) % 4) : 8 + i;
      di = diag ? 12 + ((i + 3) % 4) : 12 + i;
      q = quarter(w[i], w[bi], w[ci], w[di]);
      r[i]  = q.a;
      r[bi] = q.b;
      r[ci] = q.c;
      r[di] = q.d;
    end
    return r;
  endfunction

endpackage

FILE: hdl/chacha20_stream_xor_core.sv
// Channel | Ports                           | Direction | Request
// input   | in_valid, in_stall, in_data     | in        | one message byte and last flag
// output  | out_valid, out_stall, out_data  | out       | one XORed byte and last flag
// config  | cfg_wr_en, cfg_index, cfg_data  | in        | key word write, indexes 0..3
//
// Inside a keystream block, requests stream at one per cycle while the output does not stall.
// A byte that opens a block waits for the shared round unit to load, run 2*DOUBLE_ROUNDS rounds
// of four quarter rounds each, and make the feed-forward add.
// An accepted request passes through the queue and the output register before it reaches the output.
// Synchronous reset clears the queue, byte place, block counter and restores the key.
// A four-deep queue lets the input keep flowing while the output stalls or a block is made.
module chacha20_stream_xor_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cxs_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cxs_pkg::out_item_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [cxs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cxs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                  fifo_full;
  logic                  push;
  cxs_pkg::entry_t       push_entry;
  logic                  pop;
  cxs_pkg::entry_t       head;
  logic                  head_valid;
  cxs_pkg::gen_req_t     gen_req;
  cxs_pkg::gen_status_t  gen_status;
  cxs_pkg::block_t       ks;

  cxs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cxs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  cxs_blkgen u_blkgen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .gen_req    (gen_req),
    .gen_status (gen_status),
    .ks         (ks)
  );

  cxs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .gen_req    (gen_req),
    .gen_status (gen_status),
    .ks         (ks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: hdl/cxs_front.sv
module cxs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cxs_pkg::in_item_t in_data,
  input  logic              fifo_full,
  output logic              push,
  output cxs_pkg::entry_t   push_entry
);

  logic [5:0] pos_r;
  logic [5:0] pos_nxt;

  // Accept a request whenever the queue has room
  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  // Tag the request with its byte place and whether it opens a block
  always_comb begin
    push_entry.data_in = in_data.data_in;
    push_entry.last_in = in_data.last_in;
    push_entry.pos     = pos_r;
    push_entry.new_blk = (pos_r == 6'd0);
  end

  // Advance the byte place, drop back to zero at the end of a message
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_data.last_in ? 6'd0 : pos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hdl/cxs_fifo.sv
module cxs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cxs_pkg::entry_t push_entry,
  input  logic            pop,
  output cxs_pkg::entry_t head,
  output logic            head_valid,
  output logic            full
);

  cxs_pkg::entry_t                   mem_r [cxs_pkg::FIFO_DEPTH];
  logic [cxs_pkg::FIFO_PTR_W-1:0]    wr_ptr_r;
  logic [cxs_pkg::FIFO_PTR_W-1:0]    rd_ptr_r;
  logic [cxs_pkg::FIFO_CNT_W-1:0]    cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == cxs_pkg::FIFO_CNT_W'(cxs_pkg::FIFO_DEPTH));

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == cxs_pkg::FIFO_PTR_W'(cxs_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_r + cxs_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == cxs_pkg::FIFO_PTR_W'(cxs_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_r + cxs_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + cxs_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - cxs_pkg::FIFO_CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/cxs_blkgen.sv
module cxs_blkgen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cxs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cxs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cxs_pkg::gen_req_t               gen_req,
  output cxs_pkg::gen_status_t            gen_status,
  output cxs_pkg::block_t                 ks
);

  cxs_pkg::gen_state_t         state_r;
  cxs_pkg::gen_state_t         state_nxt;
  cxs_pkg::key_t               key_r;
  cxs_pkg::word_t              ctr_r;
  cxs_pkg::block_t             work_r;
  logic [cxs_pkg::RND_W-1:0]   rnd_r;
  cxs_pkg::block_t             init_load;
  cxs_pkg::block_t             init_ff;

  assign init_load = cxs_pkg::init_block(key_r, gen_req.counter);
  assign init_ff   = cxs_pkg::init_block(key_r, ctr_r);
  assign ks        = work_r;

  // Key registers, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= cxs_pkg::KEY_RST_0;
      key_r[1] <= cxs_pkg::KEY_RST_1;
      key_r[2] <= cxs_pkg::KEY_RST_2;
      key_r[3] <= cxs_pkg::KEY_RST_3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cxs_pkg::CFG_KEY_WORD_0: key_r[0] <= cfg_data;
        cxs_pkg::CFG_KEY_WORD_1: key_r[1] <= cfg_data;
        cxs_pkg::CFG_KEY_WORD_2: key_r[2] <= cfg_data;
        cxs_pkg::CFG_KEY_WORD_3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cxs_pkg::G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence load, rounds and feed-forward add
  always_comb begin
    state_nxt       = state_r;
    gen_status.busy = (state_r != cxs_pkg::G_IDLE);
    gen_status.done = 1'b0;
    unique case (state_r)
      cxs_pkg::G_IDLE: begin
        if (gen_req.start) begin
          state_nxt = cxs_pkg::G_ROUND;
        end
      end
      cxs_pkg::G_ROUND: begin
        if (rnd_r == cxs_pkg::RND_W'(cxs_pkg::ROUNDS - 1)) begin
          state_nxt = cxs_pkg::G_ADD;
        end
      end
      cxs_pkg::G_ADD: begin
        gen_status.done = 1'b1;
        state_nxt       = cxs_pkg::G_IDLE;
      end
      default: state_nxt = cxs_pkg::G_IDLE;
    endcase
  end

  // Round counter: even counts are column rounds, odd counts diagonal rounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (state_r == cxs_pkg::G_IDLE) begin
      rnd_r <= '0;
    end else if (state_r == cxs_pkg::G_ROUND) begin
      rnd_r <= rnd_r + cxs_pkg::RND_W'(1);
    end
  end

  // Working state, left holding the keystream block when done
  always_ff @(posedge clk) begin
    case (state_r)
      cxs_pkg::G_IDLE: begin
        if (gen_req.start) begin
          work_r <= init_load;
          ctr_r  <= gen_req.counter;
        end
      end
      cxs_pkg::G_ROUND: begin
        work_r <= cxs_pkg::round_step(work_r, rnd_r[0]);
      end
      cxs_pkg::G_ADD: begin
        for (int i = 0; i < 16; i++) begin
          work_r[i] <= work_r[i] + init_ff[i];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/cxs_back.sv
`include "chacha20_stream_xor_core_assert.svh"

module cxs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cxs_pkg::entry_t       head,
  input  logic                  head_valid,
  output logic                  pop,
  output cxs_pkg::gen_req_t     gen_req,
  input  cxs_pkg::gen_status_t  gen_status,
  input  cxs_pkg::block_t       ks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cxs_pkg::out_item_t    out_data
);

  cxs_pkg::back_state_t state_r;
  cxs_pkg::back_state_t state_nxt;
  cxs_pkg::word_t       cnt_r;
  logic                 out_valid_r;
  cxs_pkg::out_item_t   out_data_r;
  logic                 slot_free;
  cxs_pkg::word_t       ks_word;
  cxs_pkg::word_t       ks_shift;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || !out_stall;

  // Pick the keystream byte, little-endian within each word
  assign ks_word  = ks[head.pos[5:2]];
  assign ks_shift = ks_word >> {head.pos[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cxs_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Start a block on a boundary request, otherwise drain requests
  always_comb begin
    state_nxt       = state_r;
    pop             = 1'b0;
    gen_req.start   = 1'b0;
    gen_req.counter = cnt_r;
    unique case (state_r)
      cxs_pkg::B_IDLE: begin
        if (head_valid) begin
          if (head.new_blk) begin
            gen_req.start = 1'b1;
            state_nxt     = cxs_pkg::B_GEN;
          end else if (slot_free) begin
            pop = 1'b1;
          end
        end
      end
      cxs_pkg::B_GEN: begin
        if (gen_status.done) begin
          state_nxt = cxs_pkg::B_RUN;
        end
      end
      cxs_pkg::B_RUN: begin
        if (head_valid && slot_free) begin
          pop       = 1'b1;
          state_nxt = cxs_pkg::B_IDLE;
        end
      end
      default: state_nxt = cxs_pkg::B_IDLE;
    endcase
  end

  // Block counter: advance per block, clear at the end of a message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (pop && head.last_in) begin
      cnt_r <= '0;
    end else if (gen_req.start) begin
      cnt_r <= cnt_r + 32'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.data_out <= head.data_in ^ ks_shift[7:0];
      out_data_r.last_out <= head.last_in;
    end
  end

  `CXS_ASSERT_SAME(a_pop_gen_idle, pop, !gen_status.busy, "keystream read while round unit busy")
  `CXS_ASSERT_SAME(a_start_boundary, gen_req.start, head_valid && head.new_blk, "block start off boundary")
  `CXS_ASSERT_NEXT(a_done_to_run, state_r == cxs_pkg::B_GEN && gen_status.done, state_r == cxs_pkg::B_RUN, "missed block done")
  `CXS_ASSERT_NEXT(a_last_clears_cnt, pop && head.last_in, cnt_r == 32'd0, "counter not cleared at message end")

endmodule

FILE: bench/tb_chacha20_stream_xor_core.sv
`timescale 1ns / 100ps

module tb_chacha20_stream_xor_core;

  localparam int TARGET_BYTES = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int END_DRAIN    = 40;

  // Indexes past the last key word; writes there must be dropped
  localparam logic [cxs_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO =
    cxs_pkg::CFG_KEY_WORD_3 + 1'b1;
  localparam logic [cxs_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = {cxs_pkg::CFG_IDX_W{1'b1}};
  localparam logic [cxs_pkg::CFG_DATA_W-1:0] KEY_ONES = {cxs_pkg::CFG_DATA_W{1'b1}};
  localparam logic [cxs_pkg::CFG_DATA_W-1:0] KEY_ZERO = {cxs_pkg::CFG_DATA_W{1'b0}};

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [cxs_pkg::CFG_IDX_W-1:0]  idx;
    logic [cxs_pkg::CFG_DATA_W-1:0] val;
    logic [7:0]                     data;
    logic                           last;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  // Directed opening: byte extremes, message ends, key extremes, dropped writes
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h00, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'hff, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h80, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h01, 1'b1},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h00, 1'b1},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_0, KEY_ONES, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_1, KEY_ONES, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_2, KEY_ONES, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_3, KEY_ONES, 8'h00, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'hff, 1'b1},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h00, 1'b1},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_1, KEY_ZERO, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_2, KEY_ZERO, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_3, KEY_ZERO, 8'h00, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h55, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'haa, 1'b1},
    '{ROW_CFG,  CFG_IDX_UNUSED_LO, KEY_ONES, 8'h00, 1'b0},
    '{ROW_CFG,  CFG_IDX_UNUSED_HI, KEY_ONES, 8'h00, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h00, 1'b1},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_0, cxs_pkg::KEY_RST_0, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_1, cxs_pkg::KEY_RST_1, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_2, cxs_pkg::KEY_RST_2, 8'h00, 1'b0},
    '{ROW_CFG,  cxs_pkg::CFG_KEY_WORD_3, cxs_pkg::KEY_RST_3, 8'h00, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'h5a, 1'b0},
    '{ROW_BYTE, cxs_pkg::CFG_KEY_WORD_0, KEY_ZERO, 8'ha5, 1'b1}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  cxs_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cxs_pkg::out_item_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [cxs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cxs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state
  logic [63:0]        key_reg [4];
  logic [31:0]        blk_ctr;
  logic [5:0]         byte_pos;
  logic [31:0]        ks_words [16];
  logic [31:0]        mix_w [16];
  cxs_pkg::out_item_t exp_cipher_q [$];
  cxs_pkg::out_item_t exp_head;

  // Run bookkeeping
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_msgs = 0;
  int n_blocks = 0;
  int n_key_wr = 0;
  int n_key_dropped = 0;
  int stuck_cycles = 0;

  // Idle control shared between sender and receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int rx_wait = 0;
  int rx_hold = 0;

  chacha20_stream_xor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix_quarter(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Build the 64-byte keystream block for the current counter and key
  function automatic void make_keystream();
    logic [31:0] init_w [16];
    init_w[0] = cxs_pkg::SIGMA_0;
    init_w[1] = cxs_pkg::SIGMA_1;
    init_w[2] = cxs_pkg::SIGMA_2;
    init_w[3] = cxs_pkg::SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_reg[i][31:0];
      init_w[5 + 2 * i] = key_reg[i][63:32];
    end
    init_w[12] = blk_ctr;
    init_w[13] = '0;
    init_w[14] = '0;
    init_w[15] = '0;
    for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
    for (int n = 0; n < cxs_pkg::DOUBLE_ROUNDS; n++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix_w[i] + init_w[i];
  endfunction

  // XOR one byte with the keystream and advance the message position
  function automatic cxs_pkg::out_item_t chacha_xor_byte(cxs_pkg::in_item_t it);
    cxs_pkg::out_item_t r;
    logic [7:0]         ks_byte;
    if (byte_pos == 6'd0) begin
      make_keystream();
      blk_ctr = blk_ctr + 32'd1;
      n_blocks++;
    end
    ks_byte = ks_words[byte_pos[5:2]][8 * byte_pos[1:0] +: 8];
    r.data_out = it.data_in ^ ks_byte;
    r.last_out = it.last_in;
    if (it.last_in) begin
      blk_ctr = '0;
      byte_pos = '0;
      n_msgs++;
    end else begin
      byte_pos = byte_pos + 6'd1;
    end
    return r;
  endfunction

  // Track key writes and accepted bytes, check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      key_reg[0] = cxs_pkg::KEY_RST_0;
      key_reg[1] = cxs_pkg::KEY_RST_1;
      key_reg[2] = cxs_pkg::KEY_RST_2;
      key_reg[3] = cxs_pkg::KEY_RST_3;
      blk_ctr = '0;
      byte_pos = '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index <= cxs_pkg::CFG_KEY_WORD_3) begin
          key_reg[cfg_index[1:0]] = cfg_data;
          n_key_wr++;
        end else begin
          n_key_dropped++;
        end
      end
      if (out_valid && !out_stall) begin
        if (exp_cipher_q.size() == 0) begin
          $display("%0t: result %02h/%0b with no request outstanding",
                   $time, out_data.data_out, out_data.last_out);
          n_errors++;
        end else begin
          exp_head = exp_cipher_q.pop_front();
          if (out_data.data_out !== exp_head.data_out) begin
            $display("%0t: result %0d data_out expected %02h got %02h",
                     $time, n_checked, exp_head.data_out, out_data.data_out);
            n_errors++;
          end
          if (out_data.last_out !== exp_head.last_out) begin
            $display("%0t: result %0d last_out expected %0b got %0b",
                     $time, n_checked, exp_head.last_out, out_data.last_out);
            n_errors++;
          end
          n_checked++;
        end
      end
      if (in_valid && !in_stall) exp_cipher_q.push_back(chacha_xor_byte(in_data));
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
        out_stall <= (rx_wait != 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= (rx_wait != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no request moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
        $display("chacha20_stream_xor_core test failed");
        $finish;
      end
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(logic [7:0] d, logic l);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_in: d, last_in: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Write a key register once the core has drained every outstanding request
  task automatic write_key(logic [cxs_pkg::CFG_IDX_W-1:0] idx,
                           logic [cxs_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_cipher_q.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Send a message of random bytes; optionally leave it open or scatter stray ends
  task automatic send_message(int len, bit close, bit noisy);
    logic l;
    for (int i = 0; i < len; i++) begin
      l = (i == len - 1) && close;
      if (noisy) l = ($urandom_range(0, 7) == 0);
      send_byte(8'($urandom), l);
    end
  endtask

  initial begin
    int                             n_phase_msgs;
    int                             len;
    logic [cxs_pkg::CFG_IDX_W-1:0]  kidx;
    logic [cxs_pkg::CFG_DATA_W-1:0] kval;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_key(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        send_byte(dir_rows[r].data, dir_rows[r].last);
      end
    end

    // Random phases: optional key change, then a few messages
    while (n_sent < TARGET_BYTES) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        kidx = ($urandom_range(0, 7) == 0) ?
               cxs_pkg::CFG_IDX_W'($urandom_range(4, 15)) :
               cxs_pkg::CFG_IDX_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: kval = KEY_ZERO;
          1: kval = KEY_ONES;
          2: kval = {$urandom, $urandom};
          default: kval = cxs_pkg::KEY_RST_2;
        endcase
        write_key(kidx, kval);
      end
      // Once mid-run, flood the input while the receiver holds off
      if (!hold_req && n_sent > TARGET_BYTES / 2) begin
        tx_idle_on = 1'b0;
        hold_req <= 1'b1;
        send_message(80, 1'b1, 1'b0);
      end
      n_phase_msgs = $urandom_range(1, 4);
      for (int m = 0; m < n_phase_msgs; m++) begin
        case ($urandom_range(0, 5))
          0: len = $urandom_range(1, 8);
          1: len = 64;
          2: len = $urandom_range(62, 66);
          3: len = $urandom_range(127, 129);
          default: len = $urandom_range(1, 100);
        endcase
        send_message(len, !(m == n_phase_msgs - 1 && $urandom_range(0, 3) == 0),
                     $urandom_range(0, 9) == 0);
      end
    end

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_cipher_q.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("Streamed %0d bytes over %0d closed messages, %0d keystream blocks",
             n_sent, n_msgs, n_blocks);
    $display("Key writes: %0d applied, %0d to unused indexes; %0d results checked",
             n_key_wr, n_key_dropped, n_checked);
    if (n_errors == 0) begin
      $display("chacha20_stream_xor_core test passed");
    end else begin
      $display("chacha20_stream_xor_core test failed");
    end
    $finish;
  end

endmodule

FILE: chacha20_stream_xor_core.f
+incdir+hdl
hdl/cxs_pkg.sv
hdl/cxs_front.sv
hdl/cxs_fifo.sv
hdl/cxs_blkgen.sv
hdl/cxs_back.sv
hdl/chacha20_stream_xor_core.sv
bench/tb_chacha20_stream_xor_core.sv
